### hw/rtl/bcid_pkg.sv
// Shared types and constants for the blink code identity decoder.
package bcid_pkg;

    localparam int unsigned RUN_W     = 8;
    localparam int unsigned POS_W     = 4;
    localparam int unsigned BITS_W    = 10;
    localparam int unsigned ID_W      = 9;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 9;

    localparam logic [RUN_W-1:0]         RUN_MAX          = 8'hFF;
    localparam logic [RUN_W-1:0]         START_RUN_RESET  = 8'd12;
    localparam logic signed [ID_W-1:0]   INITIAL_ID_RESET = -9'sd1;
    localparam logic [POS_W-1:0]         POS_LAST_ID      = 4'd8;
    localparam logic [POS_W-1:0]         POS_PARITY_0     = 4'd9;
    localparam logic [POS_W-1:0]         POS_PARITY_1     = 4'd10;
    localparam logic [POS_W-1:0]         POS_END          = 4'd11;
    localparam logic [7:0]               ODD_BIT_MASK     = 8'hAA;
    localparam logic [7:0]               EVEN_BIT_MASK    = 8'h55;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_RUN_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ID       = 4'd1;

    // One frame sample leaving the input register.
    typedef struct packed {
        logic fire;
        logic led_on;
    } step_t;

    // One configuration write.
    typedef struct packed {
        logic                 write;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } cfg_write_t;

    // One result word.
    typedef struct packed {
        logic signed [ID_W-1:0] current_id;
        logic                   word_done;
        logic                   parity_ok;
        logic                   receiving;
    } result_t;

endpackage

### hw/rtl/bcid_in_reg.sv
// Input register stage holding one frame sample.
module bcid_in_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 led_on,
    input  logic                 out_space,
    output bcid_pkg::step_t      step
);

    logic stage_valid_reg;
    logic stage_valid_next;
    logic stage_led_reg;
    logic accept;
    logic fire;

    assign fire             = stage_valid_reg && out_space;
    assign in_ready         = !stage_valid_reg || out_space;
    assign accept           = in_valid && in_ready;
    assign stage_valid_next = accept || (stage_valid_reg && !out_space);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_led_reg <= led_on;
        end
    end

    assign step.fire   = fire;
    assign step.led_on = stage_led_reg;

endmodule

### hw/rtl/bcid_decode.sv
// Frame decoder: run counter, word assembly, parity check and configuration registers.
module bcid_decode
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bcid_pkg::step_t        step,
    input  bcid_pkg::cfg_write_t   cfg,
    output bcid_pkg::result_t      result
);

    logic [bcid_pkg::RUN_W-1:0]         start_len_reg;
    logic [bcid_pkg::RUN_W-1:0]         run_reg;
    logic [bcid_pkg::RUN_W-1:0]         run_next;
    logic [bcid_pkg::POS_W-1:0]         pos_reg;
    logic [bcid_pkg::POS_W-1:0]         pos_next;
    logic                               active_reg;
    logic                               active_next;
    logic [bcid_pkg::BITS_W-1:0]        bits_reg;
    logic [bcid_pkg::BITS_W-1:0]        bits_next;
    logic signed [bcid_pkg::ID_W-1:0]   id_reg;
    logic signed [bcid_pkg::ID_W-1:0]   id_next;
    logic                               restart;
    logic                               done;
    logic                               ok;
    logic                               parity_odd;
    logic                               parity_even;
    logic [bcid_pkg::POS_W-1:0]         bit_idx;

    assign restart     = !step.led_on && (run_reg >= start_len_reg);
    assign parity_odd  = ^(bits_reg[7:0] & bcid_pkg::ODD_BIT_MASK);
    assign parity_even = ^(bits_reg[7:0] & bcid_pkg::EVEN_BIT_MASK);

    always_comb
    begin
        run_next    = run_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        bits_next   = bits_reg;
        id_next     = id_reg;
        done        = 1'b0;
        ok          = 1'b0;
        bit_idx     = '0;

        if (step.led_on)
        begin
            if (run_reg != bcid_pkg::RUN_MAX)
            begin
                run_next = run_reg + 1'b1;
            end
        end
        else
        begin
            run_next = '0;
        end

        if (restart)
        begin
            active_next = 1'b1;
            pos_next    = '0;
            bits_next   = '0;
        end
        else if (active_reg)
        begin
            if (pos_reg >= 4'd1 && pos_reg <= bcid_pkg::POS_LAST_ID)
            begin
                // Identity bits arrive most significant first.
                bit_idx            = bcid_pkg::POS_LAST_ID - pos_reg;
                bits_next[bit_idx] = bits_reg[bit_idx] | step.led_on;
            end
            else if (pos_reg == bcid_pkg::POS_PARITY_0 || pos_reg == bcid_pkg::POS_PARITY_1)
            begin
                bit_idx            = pos_reg - 1'b1;
                bits_next[bit_idx] = bits_reg[bit_idx] | step.led_on;
            end
            else
            begin
                // End frame: each parity bit is the inverse of its group parity.
                done        = 1'b1;
                active_next = 1'b0;
                if ((parity_even == !bits_reg[8]) && (parity_odd == !bits_reg[9]))
                begin
                    ok      = 1'b1;
                    id_next = {1'b0, bits_reg[7:0]};
                end
            end
        end

        if (active_next)
        begin
            pos_next = pos_next + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_len_reg <= bcid_pkg::START_RUN_RESET;
            run_reg       <= '0;
            pos_reg       <= '0;
            active_reg    <= 1'b0;
            bits_reg      <= '0;
            id_reg        <= bcid_pkg::INITIAL_ID_RESET;
        end
        else if (cfg.write)
        begin
            if (cfg.index == bcid_pkg::REG_START_RUN_LENGTH)
            begin
                start_len_reg <= cfg.data[bcid_pkg::RUN_W-1:0];
            end
            else if (cfg.index == bcid_pkg::REG_INITIAL_ID)
            begin
                id_reg <= cfg.data;
            end
        end
        else if (step.fire)
        begin
            run_reg    <= run_next;
            pos_reg    <= pos_next;
            active_reg <= active_next;
            bits_reg   <= bits_next;
            id_reg     <= id_next;
        end
    end

    assign result.current_id = id_next;
    assign result.word_done  = done;
    assign result.parity_ok  = ok;
    assign result.receiving  = active_next;

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (pos_reg >= 4'd1 && pos_reg <= bcid_pkg::POS_END))
        else $error("bit position out of range during a word");

    a_word_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && !cfg.write && active_reg && pos_reg == bcid_pkg::POS_END && !restart)
        |=> !active_reg)
        else $error("word did not end on its end frame");

    a_good_id: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && !cfg.write && ok) |=> !id_reg[bcid_pkg::ID_W-1])
        else $error("decoded identity is not an 8-bit value");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!step.fire && !cfg.write) |=> ($stable(run_reg) && $stable(bits_reg)))
        else $error("decoder state moved without a frame");
`endif

endmodule

### hw/rtl/bcid_out_reg.sv
// Result register stage holding one result word for the consumer.
module bcid_out_reg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  bcid_pkg::result_t             result,
    output logic                          out_space,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [bcid_pkg::ID_W-1:0] current_id,
    output logic                          word_done,
    output logic                          parity_ok,
    output logic                          receiving
);

    logic              valid_reg;
    logic              valid_next;
    bcid_pkg::result_t data_reg;

    assign out_space  = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign current_id = data_reg.current_id;
    assign word_done  = data_reg.word_done;
    assign parity_ok  = data_reg.parity_ok;
    assign receiving  = data_reg.receiving;

endmodule

### hw/rtl/blink_code_id_decoder_top.sv
// Top level of the blink code identity decoder.
//
// The block takes one on/off sample of a blinking marker light per word on the
// input channel and returns one result word per sample. A run of at least
// start_run_length on frames followed by an off frame starts a code word; the
// next eight frames carry the identity most significant bit first, the two
// after that carry the parity bits, and the frame after those ends the word.
// The identity is taken only when both parity checks pass; otherwise the
// previous identity is kept and the result shows word_done without parity_ok.
// Throughput is one sample per clock cycle while the consumer keeps taking
// results. A sample sits in an input register, and the decode logic between
// that register and the result register does the whole update in a single
// pass; the result word is offered once the result register is free and has
// taken it. The result register lets a new sample be taken while a finished
// result still waits for the consumer.
// Configuration writes are always accepted at once (cfg_ready is tied high)
// and are meant to be issued only while no sample is in flight; writing the
// initial identity also replaces the identity decoded so far. There is no
// clearing pass after reset.
module blink_code_id_decoder_top
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   led_on,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [bcid_pkg::ID_W-1:0]       current_id,
    output logic                                   word_done,
    output logic                                   parity_ok,
    output logic                                   receiving,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bcid_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bcid_pkg::CFG_DAT_W-1:0]         cfg_data
);

    bcid_pkg::step_t      step;
    bcid_pkg::cfg_write_t cfg;
    bcid_pkg::result_t    result;
    logic                 out_space;

    // Register writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;
    assign cfg.write = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    bcid_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .led_on    (led_on),
        .out_space (out_space),
        .step      (step)
    );

    bcid_decode u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cfg    (cfg),
        .result (result)
    );

    bcid_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step.fire),
        .result     (result),
        .out_space  (out_space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .current_id (current_id),
        .word_done  (word_done),
        .parity_ok  (parity_ok),
        .receiving  (receiving)
    );

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the blink code identity decoder top level.
module testbench;

    // Register indexes that the block does not decode; writes to them must be ignored.
    localparam logic [bcid_pkg::CFG_IDX_W-1:0] REG_UNUSED_LOW  = 4'd2;
    localparam logic [bcid_pkg::CFG_IDX_W-1:0] REG_UNUSED_HIGH = 4'd15;

    // Far beyond what the slowest correct run needs.
    localparam int unsigned CYCLE_LIMIT = 200000;

    // Longest idle gap that the sender inserts after one sample word.
    localparam int unsigned MAX_SEND_GAP = 40;

    typedef enum int unsigned
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef logic [bcid_pkg::BITS_W-1:0] code_bits_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic                                led_on    = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [bcid_pkg::ID_W-1:0]    current_id;
    logic                                word_done;
    logic                                parity_ok;
    logic                                receiving;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [bcid_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [bcid_pkg::CFG_DAT_W-1:0]      cfg_data  = '0;

    // Shadow copy of the decoder: configuration and state.
    logic [bcid_pkg::RUN_W-1:0]          start_len_cfg;
    logic signed [bcid_pkg::ID_W-1:0]    init_id_cfg;
    logic [bcid_pkg::RUN_W-1:0]          run_count;
    logic [bcid_pkg::POS_W-1:0]          bit_pos;
    logic                                in_word;
    code_bits_t                          code_bits;
    logic signed [bcid_pkg::ID_W-1:0]    held_id;

    // Results still owed by the block, oldest first.
    bcid_pkg::result_t pending_results[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned frames_sent    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    blink_code_id_decoder_top u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .led_on     (led_on),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .current_id (current_id),
        .word_done  (word_done),
        .parity_ok  (parity_ok),
        .receiving  (receiving),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decodes one frame sample in the shadow state and returns the result word that the
    // block must produce for it.  A start mark is judged on the run count from before
    // this frame, so a restart always takes precedence over the bit or end handling.
    function automatic bcid_pkg::result_t decode_frame(input logic sample);
        bcid_pkg::result_t res;
        logic              restart;
        logic              odd_par;
        logic              even_par;
        res     = '0;
        restart = !sample && (run_count >= start_len_cfg);
        if (sample)
        begin
            if (run_count != bcid_pkg::RUN_MAX)
                run_count = run_count + 1'b1;
        end
        else
        begin
            run_count = '0;
        end
        if (restart)
        begin
            in_word   = 1'b1;
            bit_pos   = '0;
            code_bits = '0;
        end
        else if (in_word)
        begin
            if (bit_pos >= 1 && bit_pos <= bcid_pkg::POS_LAST_ID)
            begin
                // Identity bits arrive most significant first.
                code_bits = code_bits
                            | (code_bits_t'(sample) << (bcid_pkg::POS_LAST_ID - bit_pos));
            end
            else if (bit_pos == bcid_pkg::POS_PARITY_0 || bit_pos == bcid_pkg::POS_PARITY_1)
            begin
                code_bits = code_bits | (code_bits_t'(sample) << (bit_pos - 1'b1));
            end
            else
            begin
                // End frame: both parities must be the inverse of their parity bits.
                odd_par       = ^(code_bits[7:0] & bcid_pkg::ODD_BIT_MASK);
                even_par      = ^(code_bits[7:0] & bcid_pkg::EVEN_BIT_MASK);
                res.word_done = 1'b1;
                in_word       = 1'b0;
                if (even_par == !code_bits[8] && odd_par == !code_bits[9])
                begin
                    res.parity_ok = 1'b1;
                    held_id       = {1'b0, code_bits[7:0]};
                end
            end
        end
        if (in_word)
            bit_pos = bit_pos + 1'b1;
        res.current_id = held_id;
        res.receiving  = in_word;
        return res;
    endfunction

    // Returns an on-run length around the current start length.  Most runs are long
    // enough to start a code word; some fall one short or anywhere below it.
    function automatic int unsigned pick_run_length();
        int unsigned base;
        int unsigned pick;
        base = start_len_cfg;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            return base + $urandom_range(0, 3);
        else if (pick == 6)
            return (base == 0) ? 0 : base - 1;
        else if (pick == 7)
            return $urandom_range(0, base);
        else if (pick == 8)
            return base + $urandom_range(4, 20);
        return base;
    endfunction

    // Sets how often the sender idles and the receiver stalls, in percent.
    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_idle_pct  = 71;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 71;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 11;
                recv_stall_pct = 11;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Offers one sample word and waits for it to be taken; the expected result is
    // worked out at the edge of acceptance.  Must be entered at a rising edge.  The
    // valid is only lowered when an idle gap follows, so back-to-back words keep it
    // high without a second assignment in the same time step.
    task automatic send_frame(input logic sample);
        int unsigned gap;
        gap      = 0;
        in_valid <= 1'b1;
        led_on   <= sample;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(decode_frame(sample));
        frames_sent++;
        while (gap < MAX_SEND_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops sending and waits until every expected result has been received.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes two registers back to back, keeping the valid high between them.  Only
    // called with nothing in flight, so the shadow copy can follow at once.
    task automatic write_config_pair(input logic [bcid_pkg::CFG_IDX_W-1:0] idx_a,
                                     input logic [bcid_pkg::CFG_DAT_W-1:0] data_a,
                                     input logic [bcid_pkg::CFG_IDX_W-1:0] idx_b,
                                     input logic [bcid_pkg::CFG_DAT_W-1:0] data_b);
        logic [bcid_pkg::CFG_IDX_W-1:0] idx;
        logic [bcid_pkg::CFG_DAT_W-1:0] data;
        for (int n = 0; n < 2; n++)
        begin
            idx       = (n == 0) ? idx_a : idx_b;
            data      = (n == 0) ? data_a : data_b;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx)
                bcid_pkg::REG_START_RUN_LENGTH: start_len_cfg = data[bcid_pkg::RUN_W-1:0];
                bcid_pkg::REG_INITIAL_ID:
                begin
                    // Writing the initial identity also replaces the decoded one.
                    init_id_cfg = data;
                    held_id     = data;
                end
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Sends one blink code: an on-run, the start off frame, eight identity bits, the
    // two parity bits (optionally corrupted) and the end frame.
    task automatic send_code_word(input int unsigned run,
                                  input logic [7:0] id,
                                  input logic [1:0] parity_flip,
                                  input logic end_sample);
        logic pb0;
        logic pb1;
        pb0 = ~^(id & bcid_pkg::EVEN_BIT_MASK) ^ parity_flip[0];
        pb1 = ~^(id & bcid_pkg::ODD_BIT_MASK) ^ parity_flip[1];
        repeat (run) send_frame(1'b1);
        send_frame(1'b0);
        for (int i = 7; i >= 0; i--)
            send_frame(id[i]);
        send_frame(pb0);
        send_frame(pb1);
        send_frame(end_sample);
    endtask

    // Mostly well-formed code words with random content, the rest loose noise frames.
    // A quarter of the code words carry broken parity.
    task automatic run_random(input int unsigned count);
        int unsigned target;
        target = frames_sent + count;
        while (frames_sent < target)
        begin
            if ($urandom_range(0, 9) < 8)
                send_code_word(pick_run_length(), 8'($urandom_range(0, 255)),
                               ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : 2'b00,
                               1'($urandom_range(0, 1)));
            else
                repeat ($urandom_range(1, 6)) send_frame(1'($urandom_range(0, 1)));
        end
    endtask

    // Straight after reset the identity must read as unknown.
    task automatic test_reset_state();
        send_frame(1'b0);
    endtask

    // With a start length of zero every off frame starts a code word, so only an
    // all-ones identity with both parity bits set survives to its end frame.
    task automatic test_zero_start_length();
        wait_for_results();
        write_config_pair(bcid_pkg::REG_START_RUN_LENGTH, 9'h000,
                          bcid_pkg::REG_INITIAL_ID, 9'h0AA);
        send_frame(1'b0);
        repeat (11) send_frame(1'b1);
    endtask

    // Writing the initial identity overwrites the identity decoded before; the ninth
    // data bit has no place in the start length register.
    task automatic test_initial_id_write();
        wait_for_results();
        write_config_pair(bcid_pkg::REG_START_RUN_LENGTH, 9'h101,
                          bcid_pkg::REG_INITIAL_ID, 9'h100);
        send_frame(1'b1);
    endtask

    // Writes to undecoded indexes must change nothing.
    task automatic test_unknown_index();
        wait_for_results();
        write_config_pair(REG_UNUSED_HIGH, 9'h1FF, REG_UNUSED_LOW, 9'h000);
        send_frame(1'b1);
    endtask

    // A fresh start mark in the middle of a code word abandons it.
    task automatic test_restart_in_word();
        send_frame(1'b1);
        send_frame(1'b0);
        send_frame(1'b1);
        send_frame(1'b0);
    endtask

    // An all-zero identity whose end frame is itself a start mark: the restart wins.
    task automatic test_restart_on_end_frame();
        send_code_word(1, 8'h00, 2'b00, 1'b0);
    endtask

    task automatic test_random_short_runs();
        wait_for_results();
        set_idle_mode(IDLE_NONE);
        write_config_pair(bcid_pkg::REG_START_RUN_LENGTH, 9'($urandom_range(4, 10)),
                          bcid_pkg::REG_INITIAL_ID, 9'($urandom_range(0, 255)));
        run_random(120);
    endtask

    task automatic test_random_sender_idle();
        wait_for_results();
        set_idle_mode(IDLE_SENDER);
        write_config_pair(bcid_pkg::REG_START_RUN_LENGTH, 9'h001,
                          bcid_pkg::REG_INITIAL_ID, 9'h1FF);
        run_random(150);
    endtask

    // Halfway through, the sender holds off until the block has caught up completely.
    task automatic test_random_receiver_stall();
        wait_for_results();
        set_idle_mode(IDLE_RECEIVER);
        write_config_pair(bcid_pkg::REG_START_RUN_LENGTH, 9'($urandom_range(2, 12)),
                          bcid_pkg::REG_INITIAL_ID, 9'($urandom_range(0, 255)));
        run_random(80);
        wait_for_results();
        run_random(80);
    endtask

    task automatic test_random_both_idle();
        wait_for_results();
        set_idle_mode(IDLE_BOTH);
        write_config_pair(bcid_pkg::REG_START_RUN_LENGTH, 9'h000,
                          bcid_pkg::REG_INITIAL_ID, 9'h100);
        run_random(120);
    endtask

    // Largest start length: an on-run longer than the counter can hold must saturate
    // and still count as a start mark.
    task automatic test_run_saturation();
        wait_for_results();
        set_idle_mode(IDLE_NONE);
        write_config_pair(bcid_pkg::REG_START_RUN_LENGTH, 9'h0FF,
                          bcid_pkg::REG_INITIAL_ID, 9'h0FF);
        send_code_word(300, 8'($urandom_range(0, 255)), 2'b00, 1'b1);
    endtask

    task automatic test_random_reset_values();
        wait_for_results();
        set_idle_mode(IDLE_SENDER);
        write_config_pair(bcid_pkg::REG_START_RUN_LENGTH, 9'(bcid_pkg::START_RUN_RESET),
                          bcid_pkg::REG_INITIAL_ID, bcid_pkg::INITIAL_ID_RESET);
        run_random(100);
    endtask

    // The receiver side: ready is redrawn on every edge at the current stall rate.
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Every result word taken is compared with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        bcid_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word received with no expected result pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (current_id !== want.current_id)
                begin
                    $error("current_id: expected %0d, actual %0d", want.current_id, current_id);
                    mismatch_count++;
                end
                if (word_done !== want.word_done)
                begin
                    $error("word_done: expected %0b, actual %0b", want.word_done, word_done);
                    mismatch_count++;
                end
                if (parity_ok !== want.parity_ok)
                begin
                    $error("parity_ok: expected %0b, actual %0b", want.parity_ok, parity_ok);
                    mismatch_count++;
                end
                if (receiving !== want.receiving)
                begin
                    $error("receiving: expected %0b, actual %0b", want.receiving, receiving);
                    mismatch_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        // The shadow state starts from the reset values of the block.
        start_len_cfg = bcid_pkg::START_RUN_RESET;
        init_id_cfg   = bcid_pkg::INITIAL_ID_RESET;
        held_id       = bcid_pkg::INITIAL_ID_RESET;
        run_count     = '0;
        bit_pos       = '0;
        in_word       = 1'b0;
        code_bits     = '0;
        set_idle_mode(IDLE_NONE);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_zero_start_length();
        test_initial_id_write();
        test_unknown_index();
        test_restart_in_word();
        test_restart_on_end_frame();
        test_random_short_runs();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_run_saturation();
        test_random_reset_values();

        // Let the last results arrive, then keep watching for any stray word.
        wait_for_results();
        repeat (4) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
